### hw/rtl/evdr_pkg.sv
// evdr_pkg: shared types and constants for the Euler-velocity dead reckoning block.
// No dependencies.
`default_nettype none
package evdr_pkg;
  localparam int PHASE_BITS = 24;
  // sine polynomial coefficients, Q15
  localparam logic [15:0] COEF_A = 16'd51472;
  localparam logic [15:0] COEF_B = 16'd21024;
  localparam logic [15:0] COEF_C = 16'd2320;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MAT,
    ST_DOT,
    ST_ACC
  } evdr_state_t;
endpackage
`default_nettype wire

### hw/rtl/evdr_front.sv
// evdr_front: input capture and one-deep hand-off queue to the back end.
// Depends on evdr_pkg.
`default_nettype none
module evdr_front import evdr_pkg::*; #(
  parameter int W = 96
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_word,
  output logic              q_valid,
  input  wire logic         q_ready,
  output logic [W-1:0]      q_word
);
  logic [W-1:0] word_r;
  logic         full_r;
  assign in_ready = !full_r || q_ready;
  assign q_valid  = full_r;
  assign q_word   = word_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_ready) begin
      full_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end
`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full_r && !q_ready |=> full_r && $stable(word_r)) else $error("queue lost word");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> in_ready) else $error("empty queue not ready");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> full_r) else $error("accepted word not queued");
`endif
endmodule
`default_nettype wire

### hw/rtl/evdr_back.sv
// evdr_back: trig pipeline, matrix, rotation and saturating accumulation sequencer.
// Depends on evdr_pkg.
`default_nettype none
module evdr_back import evdr_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int VEL_BITS   = 16,
  parameter int ACC_BITS   = 40
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  input  wire logic signed [VEL_BITS-1:0] vx,
  input  wire logic signed [VEL_BITS-1:0] vy,
  input  wire logic signed [VEL_BITS-1:0] vz,
  input  wire logic [ANGLE_BITS-1:0]      ax,
  input  wire logic [ANGLE_BITS-1:0]      ay,
  input  wire logic [ANGLE_BITS-1:0]      az,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [ACC_BITS-1:0]      pos_x,
  output logic signed [ACC_BITS-1:0]      pos_y,
  output logic                            saturated
);
  localparam int PW = VEL_BITS + 19;
  localparam int SW = PW + 2;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  evdr_state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  logic signed [16:0] trig_r [6];
  logic signed [16:0] sysx_r, cysx_r;
  logic signed [17:0] m_r [6];
  logic signed [VEL_BITS-1:0] v_r [3];
  logic [ANGLE_BITS-1:0] a_r [3];
  logic signed [SW-1:0] sum_r [2];
  logic signed [ACC_BITS-1:0] px_r, py_r;
  logic clip_r;
  logic ovalid_r;
  logic acc_fire;

  // sine pipeline: one multiply per stage
  logic [PHASE_BITS-1:0] ph;
  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]  quad;
  logic [22:0] z22;
  logic [15:0] z0;
  logic [31:0] z2p;
  logic [31:0] tp;
  logic [31:0] tp2;
  logic [31:0] sp;
  logic [15:0] smag;
  logic signed [16:0] sine;
  logic s0_v_r, s1_v_r, s2_v_r;
  logic [2:0]  s0_idx_r, s1_idx_r, s2_idx_r;
  logic [1:0]  s0_q_r, s1_q_r, s2_q_r;
  logic [15:0] s0_z_r, s1_z_r, s2_z_r;
  logic [15:0] s0_z2_r, s1_z2_r;
  logic [16:0] s1_t_r, s2_t_r;

  function automatic logic signed [16:0] qm(input logic signed [16:0] a,
                                            input logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b;
    qm = p[31:15];
  endfunction

  // trig issue order: 0 sx 1 cx 2 sy 3 cy 4 sz 5 cz
  always_comb begin
    case (cnt_r[2:1])
      2'd0:    ang = a_r[0];
      2'd1:    ang = a_r[1];
      default: ang = a_r[2];
    endcase
    ph   = (PHASE_BITS'(ang) << (PHASE_BITS - ANGLE_BITS)) + (cnt_r[0] ? QUARTER : '0);
    quad = ph[PHASE_BITS-1 -: 2];
    z22  = quad[0] ? (23'd4194304 - {1'b0, ph[21:0]}) : {1'b0, ph[21:0]};
    z0   = z22[22:7];
    z2p  = z0 * z0;
    tp   = COEF_C * s0_z2_r;
    tp2  = s1_t_r * s1_z2_r;
    sp   = s2_z_r * s2_t_r;
    smag = (sp[31:15] > 17'd32767) ? 16'd32767 : sp[30:15];
    sine = s2_q_r[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= (state_r == ST_TRIG) && (cnt_r < 4'd6);
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_r <= cnt_r[2:0];
    s0_q_r   <= quad;
    s0_z_r   <= z0;
    s0_z2_r  <= z2p[30:15];
    s1_idx_r <= s0_idx_r;
    s1_q_r   <= s0_q_r;
    s1_z_r   <= s0_z_r;
    s1_z2_r  <= s0_z2_r;
    s1_t_r   <= {1'b0, COEF_B} - tp[31:15];
    s2_idx_r <= s1_idx_r;
    s2_q_r   <= s1_q_r;
    s2_z_r   <= s1_z_r;
    s2_t_r   <= {1'b0, COEF_A} - tp2[31:15];
    if (s2_v_r) begin
      trig_r[s2_idx_r] <= sine;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_TRIG;
      ST_TRIG: if (cnt_r == 4'd8) state_nxt = ST_MAT;
      ST_MAT:  if (cnt_r == 4'd1) state_nxt = ST_DOT;
      ST_DOT:  if (cnt_r == 4'd2) state_nxt = ST_ACC;
      ST_ACC:  if (!ovalid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state_r == ST_IDLE);
    out_valid = ovalid_r;
    acc_fire  = (state_r == ST_ACC) && (!ovalid_r || out_ready);
  end

  assign pos_x = px_r;
  assign pos_y = py_r;
  assign saturated = clip_r;

  // one velocity by element product per element pair
  logic signed [PW-1:0] pxp, pyp;
  always_comb begin
    pxp = v_r[cnt_r[1:0]] * m_r[{1'b0, cnt_r[1:0]}];
    pyp = v_r[cnt_r[1:0]] * m_r[3'd3 + {1'b0, cnt_r[1:0]}];
  end

  function automatic logic signed [ACC_BITS-1:0] sadd(
      input logic signed [ACC_BITS-1:0] a, input logic signed [SW-1:0] s,
      output logic c);
    localparam int EW = (ACC_BITS > SW ? ACC_BITS : SW) + 2;
    logic signed [EW-1:0] d, t, mx, mn;
    d  = EW'(s >>> 15);
    t  = EW'(a) + d;
    mx = EW'({1'b0, {(ACC_BITS-1){1'b1}}});
    mn = -mx - 1;
    c = 1'b0;
    if (t > mx) begin c = 1'b1; sadd = ACC_BITS'(mx); end
    else if (t < mn) begin c = 1'b1; sadd = ACC_BITS'(mn); end
    else sadd = ACC_BITS'(t);
  endfunction

  logic cx_c, cy_c;
  logic signed [ACC_BITS-1:0] nx_c, ny_c;
  always_comb begin
    nx_c = sadd(px_r, sum_r[0], cx_c);
    ny_c = sadd(py_r, sum_r[1], cy_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      px_r <= '0;
      py_r <= '0;
      clip_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_fire) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (q_valid) begin
            v_r[0] <= vx; v_r[1] <= vy; v_r[2] <= vz;
            a_r[0] <= ax; a_r[1] <= ay; a_r[2] <= az;
          end
        end
        ST_TRIG: begin
          cnt_r <= (cnt_r == 4'd8) ? 4'd0 : cnt_r + 4'd1;
        end
        ST_MAT: begin
          // trig_r: 0 sx 1 cx 2 sy 3 cy 4 sz 5 cz
          if (cnt_r == 4'd0) begin
            sysx_r <= qm(trig_r[2], trig_r[0]);
            cysx_r <= qm(trig_r[3], trig_r[0]);
            m_r[0] <= 18'(qm(trig_r[1], trig_r[5]));
            m_r[1] <= -18'(qm(trig_r[3], trig_r[4]));
            m_r[2] <= 18'(qm(trig_r[2], trig_r[4]));
            m_r[3] <= 18'(qm(trig_r[1], trig_r[4]));
            m_r[4] <= 18'(qm(trig_r[3], trig_r[5]));
            m_r[5] <= -18'(qm(trig_r[2], trig_r[5]));
            cnt_r <= 4'd1;
          end else begin
            m_r[1] <= m_r[1] + 18'(qm(sysx_r, trig_r[5]));
            m_r[2] <= m_r[2] + 18'(qm(cysx_r, trig_r[5]));
            m_r[4] <= m_r[4] + 18'(qm(sysx_r, trig_r[4]));
            m_r[5] <= m_r[5] + 18'(qm(cysx_r, trig_r[4]));
            sum_r[0] <= '0; sum_r[1] <= '0;
            cnt_r <= '0;
          end
        end
        ST_DOT: begin
          sum_r[0] <= sum_r[0] + SW'(pxp);
          sum_r[1] <= sum_r[1] + SW'(pyp);
          cnt_r <= cnt_r + 4'd1;
        end
        ST_ACC: begin
          if (acc_fire) begin
            px_r <= nx_c;
            py_r <= ny_c;
            clip_r <= cx_c | cy_c;
          end
        end
        default: ;
      endcase
    end
  end
`ifndef ASSERT_OFF
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(px_r) && $stable(py_r))
    else $error("result moved");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC && !out_valid |=> out_valid) else $error("no result after accumulate");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAT |-> !s0_v_r && !s1_v_r && !s2_v_r) else $error("trig not drained");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRIG |-> cnt_r <= 4'd8) else $error("trig count overrun");
`endif
endmodule
`default_nettype wire

### hw/rtl/euler_velocity_dead_reckoning.sv
// euler_velocity_dead_reckoning: top level, front queue and back sequencer.
// Depends on evdr_pkg, evdr_front, evdr_back.
//
// Usage:
//  in_* stream: one word per integration tick carrying body velocity and three
//  Euler angles. out_* stream: one word per tick with updated X/Y position.
//  The front holds one word so the next tick is taken while the back works.
//  Back per tick: a hand-off step, a trig phase (six sines issued one per
//  cycle into a 4-stage polynomial pipeline, one multiply per stage), a
//  matrix phase, a dot-product phase over three element pairs and an
//  accumulate step; the back takes a new word only once back in idle.
//  The accumulators double as the output register: the back starts the next
//  tick while a result waits and stalls only at its accumulate step.
//  Reset (rst_n low, synchronous) clears both accumulators, the result valid
//  and the queue. When out_tready is low the result holds; the back stalls at
//  accumulate, the front fills and then in_tready drops.
`default_nettype none
module euler_velocity_dead_reckoning import evdr_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int VEL_BITS   = 16,
  parameter int ACC_BITS   = 40
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // vel_body_x, vel_body_y, vel_body_z, angle_x, angle_y, angle_z (low bits up)
  input  wire logic [((3*VEL_BITS+3*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // pos_x, pos_y (low bits up)
  output logic [((2*ACC_BITS+7)/8)*8-1:0] out_tdata,
  // saturated
  output logic      out_tuser
);
  localparam int W  = 3*VEL_BITS + 3*ANGLE_BITS;
  localparam int OW = ((2*ACC_BITS+7)/8)*8;
  logic q_valid, q_ready;
  logic [W-1:0] q_word;
  logic signed [ACC_BITS-1:0] pos_x, pos_y;

  evdr_front #(.W(W)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_word(in_tdata[W-1:0]), .q_valid, .q_ready, .q_word
  );

  evdr_back #(.ANGLE_BITS(ANGLE_BITS), .VEL_BITS(VEL_BITS), .ACC_BITS(ACC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready,
    .vx(q_word[VEL_BITS-1:0]),
    .vy(q_word[2*VEL_BITS-1:VEL_BITS]),
    .vz(q_word[3*VEL_BITS-1:2*VEL_BITS]),
    .ax(q_word[3*VEL_BITS+ANGLE_BITS-1:3*VEL_BITS]),
    .ay(q_word[3*VEL_BITS+2*ANGLE_BITS-1:3*VEL_BITS+ANGLE_BITS]),
    .az(q_word[W-1:3*VEL_BITS+2*ANGLE_BITS]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .pos_x, .pos_y, .saturated(out_tuser)
  );

  assign out_tdata = OW'({pos_y, pos_x});
endmodule
`default_nettype wire
